/* rtl/sstw_pkg.sv */
// Shared types, constants and a helper function for the two-wire display serializer.
`timescale 1ns / 1ps
package sstw_pkg;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_NUMBER = 2'd1,
        CMD_RAW    = 2'd2,
        CMD_BRIGHT = 2'd3
    } cmd_t;

    localparam int DIGIT_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int RAW_BYTES       = 4;
    localparam int BCD_DIGITS      = 5;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    localparam logic [7:0]  ADDR_AUTO_INC  = 8'hC0;
    localparam logic [7:0]  BRIGHT_BASE    = 8'h80;
    localparam logic [7:0]  DISPLAY_ON_BIT = 8'h08;
    localparam logic [15:0] TPS_RESET      = 16'd1;

    // Steps per section of a frame
    localparam logic [4:0] START_STEPS = 5'd3;
    localparam logic [4:0] BYTE_STEPS  = 5'd27;
    localparam logic [4:0] STOP_STEPS  = 5'd4;
    localparam logic [4:0] FIRST_STEPS = 5'd30;

    // Step indices inside a section
    localparam logic [4:0] STEP_A    = 5'd0;
    localparam logic [4:0] STEP_B    = 5'd1;
    localparam logic [4:0] STEP_C    = 5'd2;
    localparam logic [4:0] ACK_CLK_LO = 5'd24;
    localparam logic [4:0] ACK_DAT_HI = 5'd25;
    localparam logic [4:0] BIT_STEPS  = 5'd24;

    // Phase within one data bit
    localparam logic [1:0] PH_CLK_LO = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;

    // Segment pattern of one decimal digit
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

/* rtl/seven_segment_two_wire_serializer.sv */
// Top level of the two-wire seven-segment display serializer.
// An item's result reaches m_tvalid via the input stage with number conversion, one
// queue slot and the output register. Throughput: one item per cycle unless m_tready
// stalls the output; the frame advances at most one step per item.
// Reset (aresetn low, synchronous): pins low, idle, queue empty, ticks_per_step 1.
`timescale 1ns / 1ps
module seven_segment_two_wire_serializer #(
    parameter int DIGIT_COUNT = sstw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: ticks_per_step
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [15:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tuser: cmd[1:0]
    input  logic [1:0]                     s_tuser,
    // tdata: number_value[15:0], segment_byte_0[23:16], segment_byte_1[31:24],
    // segment_byte_2[39:32], segment_byte_3[47:40], brightness_level[50:48],
    // display_on[51], zero fill
    input  logic [sstw_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tlast: frame_done
    output logic                           m_tlast,
    // tdata: clock_line[0], data_line[1], busy_res[2], command_rejected[3], zero fill
    output logic [sstw_pkg::M_TDATA_W-1:0] m_tdata
);
    import sstw_pkg::*;

    localparam int ENTRY_W = 2 + 8 * (DIGIT_COUNT + 1);

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    sstw_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sstw_queue #(.WIDTH(ENTRY_W)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sstw_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/sstw_front.sv */
// Front end: accepts command items, converts numbers to digits and builds frame bytes.
`timescale 1ns / 1ps
module sstw_front #(
    parameter int DIGIT_COUNT = sstw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_tuser,
    input  logic [sstw_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           push_valid,
    input  logic                           push_ready,
    output logic [2+8*(DIGIT_COUNT+1)-1:0] push_data
);
    import sstw_pkg::*;

    localparam int FRAME_MAX = DIGIT_COUNT + 1;
    localparam int BYTES_W   = 8 * FRAME_MAX;

    // Eight double-dabble steps: add three to digits above four, shift in a bit
    function automatic logic [19:0] dabble8(input logic [19:0] bcd_in,
                                            input logic [7:0] bits);
        logic [19:0] bcd;
        bcd = bcd_in;
        for (int k = 0; k < 8; k++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (bcd[d*4 +: 4] > 4'd4) begin
                    bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[18:0], bits[7-k]};
        end
        return bcd;
    endfunction

    logic        st_valid_reg;
    cmd_t        st_cmd_reg;
    logic [19:0] st_bcd_reg;
    logic [7:0]  st_low_reg;
    logic [31:0] st_raw_reg;
    logic [3:0]  st_bright_reg;

    logic              accept;
    logic              push;
    logic [19:0]       bcd_full;
    logic [BYTES_W-1:0] frame_bytes;

    assign push     = st_valid_reg && push_ready;
    assign s_tready = !st_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;

    // Hold valid of the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (push) begin
            st_valid_reg <= 1'b0;
        end
    end

    // Capture the item with the upper half of the number already converted
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_cmd_reg    <= cmd_t'(s_tuser);
            st_bcd_reg    <= dabble8(20'd0, s_tdata[15:8]);
            st_low_reg    <= s_tdata[7:0];
            st_raw_reg    <= s_tdata[47:16];
            st_bright_reg <= s_tdata[51:48];
        end
    end

    // Finish the conversion on the lower half
    assign bcd_full = dabble8(st_bcd_reg, st_low_reg);

    // First byte: address command, or the brightness command
    assign frame_bytes[7:0] = (st_cmd_reg == CMD_BRIGHT)
        ? (BRIGHT_BASE | (st_bright_reg[3] ? DISPLAY_ON_BIT : 8'h00)
           | {5'd0, st_bright_reg[2:0]})
        : ADDR_AUTO_INC;

    // Digit bytes, leftmost first
    for (genvar gi = 0; gi < DIGIT_COUNT; gi++) begin : g_byte
        localparam int PLACE = DIGIT_COUNT - 1 - gi;
        logic [7:0] num_seg;
        logic [7:0] raw_seg;
        if (PLACE < BCD_DIGITS) begin : g_num
            assign num_seg = seg_of(bcd_full[PLACE*4 +: 4]);
        end else begin : g_num_zero
            // place above the largest number: always a shown zero
            assign num_seg = seg_of(4'd0);
        end
        if (gi < RAW_BYTES) begin : g_raw
            assign raw_seg = st_raw_reg[gi*8 +: 8];
        end else begin : g_raw_zero
            assign raw_seg = 8'h00;
        end
        assign frame_bytes[(gi+1)*8 +: 8] = (st_cmd_reg == CMD_NUMBER) ? num_seg
                                          : (st_cmd_reg == CMD_RAW)    ? raw_seg
                                          : 8'h00;
    end

    assign push_valid = st_valid_reg;
    assign push_data  = {frame_bytes, st_cmd_reg};

endmodule

/* rtl/sstw_queue.sv */
// Short register queue between the front end and the serializer.
`timescale 1ns / 1ps
module sstw_queue #(
    parameter int WIDTH = 42
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import sstw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic push;
    logic pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/sstw_back.sv */
// Back end: steps the two-wire frame at most once per item and registers the result.
`timescale 1ns / 1ps
module sstw_back #(
    parameter int DIGIT_COUNT = sstw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [15:0]                    cfg_data,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  logic [2+8*(DIGIT_COUNT+1)-1:0] pop_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           m_tlast,
    output logic [sstw_pkg::M_TDATA_W-1:0] m_tdata
);
    import sstw_pkg::*;

    localparam int FRAME_MAX = DIGIT_COUNT + 1;
    localparam int IDX_W     = $clog2(FRAME_MAX);
    localparam logic [2:0] FRAME_LEN = 3'(FRAME_MAX);

    // New pin levels {clock, data} for step s of section pos
    function automatic logic [1:0] drive(input logic [2:0] pos, input logic [4:0] s,
                                         input logic [2:0] len, input logic [7:0] b,
                                         input logic clk_in, input logic dat_in);
        logic       clk;
        logic       dat;
        logic [4:0] t;
        logic [8:0] prod;
        logic [2:0] bit_idx;
        logic [4:0] three_bits;
        logic [1:0] ph;
        clk = clk_in;
        dat = dat_in;
        t = (pos == 3'd0) ? s - START_STEPS : s;
        // t / 3 through a reciprocal, exact below 24
        prod = {4'd0, t} * 9'd11;
        bit_idx = prod[7:5];
        three_bits = {2'd0, bit_idx} + {1'b0, bit_idx, 1'b0};
        ph = 2'(t - three_bits);
        if (pos >= len) begin
            // stop condition
            priority case (s)
                STEP_A:  clk = 1'b0;
                STEP_B:  dat = 1'b0;
                STEP_C:  clk = 1'b1;
                default: dat = 1'b1;
            endcase
        end else if (pos == 3'd0 && s < START_STEPS) begin
            // start condition
            priority case (s)
                STEP_A:  dat = 1'b1;
                STEP_B:  clk = 1'b1;
                default: dat = 1'b0;
            endcase
        end else if (t < BIT_STEPS) begin
            priority case (ph)
                PH_CLK_LO: clk = 1'b0;
                PH_DATA:   dat = b[bit_idx];
                default:   clk = 1'b1;
            endcase
        end else if (t == ACK_CLK_LO) begin
            clk = 1'b0;
        end else if (t == ACK_DAT_HI) begin
            dat = 1'b1;
        end else begin
            clk = 1'b1;
        end
        return {clk, dat};
    endfunction

    logic [15:0] tps_reg;
    logic        clk_reg,  clk_next;
    logic        dat_reg,  dat_next;
    logic [7:0]  bytes_reg [FRAME_MAX];
    logic [2:0]  len_reg,  len_next;
    logic [2:0]  pos_reg,  pos_next;
    logic [4:0]  step_reg, step_next;
    logic [15:0] pre_reg,  pre_next;
    logic        sending_reg, sending_next;
    logic        m_tvalid_reg;
    logic        m_tlast_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic        fire;
    logic        load;
    logic        done;
    logic        rejected;
    cmd_t        entry_cmd;
    logic [4:0]  sec_steps;
    logic [4:0]  step_inc;
    logic        step_fits;
    logic [2:0]  tgt_pos;
    logic [4:0]  tgt_step;
    logic [7:0]  tgt_byte;
    logic [1:0]  levels;

    assign entry_cmd = cmd_t'(pop_data[1:0]);
    assign fire      = pop_valid && (!m_tvalid_reg || m_tready);
    assign pop_ready = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Pick the next step and its pin levels
    always_comb begin
        sec_steps = (pos_reg >= len_reg) ? STOP_STEPS
                  : (pos_reg == 3'd0)    ? FIRST_STEPS : BYTE_STEPS;
        step_inc  = step_reg + 5'd1;
        step_fits = step_inc < sec_steps;
        tgt_pos   = step_fits ? pos_reg : pos_reg + 3'd1;
        tgt_step  = step_fits ? step_inc : 5'd0;
        tgt_byte  = (tgt_pos < FRAME_LEN) ? bytes_reg[tgt_pos[IDX_W-1:0]] : 8'h00;
        levels    = drive(tgt_pos, tgt_step, len_reg, tgt_byte, clk_reg, dat_reg);
    end

    // Advance the frame by one item
    always_comb begin
        clk_next     = clk_reg;
        dat_next     = dat_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        pre_next     = pre_reg;
        sending_next = sending_reg;
        done         = 1'b0;
        rejected     = 1'b0;
        load         = 1'b0;
        if (fire) begin
            if (sending_reg) begin
                rejected = (entry_cmd != CMD_TICK);
                if (pre_reg >= tps_reg) begin
                    if (step_fits || pos_reg < len_reg) begin
                        pos_next  = tgt_pos;
                        step_next = tgt_step;
                        clk_next  = levels[1];
                        dat_next  = levels[0];
                        pre_next  = 16'd1;
                    end else begin
                        sending_next = 1'b0;
                        done         = 1'b1;
                        pre_next     = 16'd0;
                    end
                end else begin
                    pre_next = pre_reg + 16'd1;
                end
            end else if (entry_cmd != CMD_TICK) begin
                // start: first step raises data
                load         = 1'b1;
                len_next     = (entry_cmd == CMD_BRIGHT) ? 3'd1 : FRAME_LEN;
                pos_next     = 3'd0;
                step_next    = 5'd0;
                dat_next     = 1'b1;
                pre_next     = 16'd1;
                sending_next = 1'b1;
            end
        end
    end

    // Frame state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg     <= TPS_RESET;
            clk_reg     <= 1'b0;
            dat_reg     <= 1'b0;
            len_reg     <= 3'd0;
            pos_reg     <= 3'd0;
            step_reg    <= 5'd0;
            pre_reg     <= 16'd0;
            sending_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                tps_reg <= cfg_data;
            end
            clk_reg     <= clk_next;
            dat_reg     <= dat_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            step_reg    <= step_next;
            pre_reg     <= pre_next;
            sending_reg <= sending_next;
        end
    end

    // Load frame bytes on a start
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < FRAME_MAX; i++) begin
                bytes_reg[i] <= pop_data[2 + i*8 +: 8];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {4'd0, rejected, sending_next, dat_next, clk_next};
            m_tlast_reg <= done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/sstw_checker.sv */
// Port-level checks for the serializer and their binding to the top level.
`timescale 1ns / 1ps
module sstw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic                           m_tlast,
    input logic [sstw_pkg::M_TDATA_W-1:0] m_tdata
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A finished frame leaves the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[2])
        else $error("busy after frame end");

    // A stop condition leaves both lines high
    a_done_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[0] && m_tdata[1])
        else $error("lines not high after stop");

    // A dropped command only happens during a frame
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] && !m_tlast |-> m_tdata[2])
        else $error("rejected item while idle");

endmodule

bind seven_segment_two_wire_serializer sstw_checker u_sstw_checker (.*);
